### hw/rtl/c_source_lexer_top_assert.svh
// Assertion macros used by the checker file.
`ifndef C_SOURCE_LEXER_TOP_ASSERT_SVH
`define C_SOURCE_LEXER_TOP_ASSERT_SVH
`define CSL_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("%m: lbl failed");
`define CSL_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("%m: lbl failed");
`endif

### hw/rtl/csl_pkg.sv
// ----------------------------------------------------------------------------
// csl_pkg
// Shared types, constants and character tables for the C source lexer.
// ----------------------------------------------------------------------------
package csl_pkg;

  localparam int unsigned PosBitsDef = 16;
  localparam int unsigned NumKw      = 44;
  localparam int unsigned KwLen      = 15;

  localparam logic [6:0] TypeString = 7'd24;
  localparam logic [6:0] TypeNumber = 7'd25;
  localparam logic [6:0] TypeIdent  = 7'd26;
  localparam logic [6:0] TypeKw0    = 7'd27;

  typedef enum logic [1:0] {
    ModeIdle = 2'd0,
    ModeNum  = 2'd1,
    ModeWord = 2'd2,
    ModeStr  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [6:0]  tok_type;
    logic [15:0] start;
    logic [15:0] len;
    logic        err;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic       nl;
    result_t    r0;
    result_t    r1;
  } step_t;

  typedef logic [KwLen*8-1:0] kw_str_t;

  function automatic kw_str_t kw_str(input logic [5:0] k);
    kw_str_t s;
    s = '0;
    case (k)
      6'd0:  s = {"auto"};
      6'd1:  s = {"break"};
      6'd2:  s = {"case"};
      6'd3:  s = {"char"};
      6'd4:  s = {"const"};
      6'd5:  s = {"continue"};
      6'd6:  s = {"default"};
      6'd7:  s = {"do"};
      6'd8:  s = {"double"};
      6'd9:  s = {"else"};
      6'd10: s = {"enum"};
      6'd11: s = {"extern"};
      6'd12: s = {"float"};
      6'd13: s = {"for"};
      6'd14: s = {"goto"};
      6'd15: s = {"if"};
      6'd16: s = {"inline"};
      6'd17: s = {"int"};
      6'd18: s = {"long"};
      6'd19: s = {"register"};
      6'd20: s = {"restrict"};
      6'd21: s = {"return"};
      6'd22: s = {"short"};
      6'd23: s = {"signed"};
      6'd24: s = {"sizeof"};
      6'd25: s = {"static"};
      6'd26: s = {"struct"};
      6'd27: s = {"switch"};
      6'd28: s = {"typedef"};
      6'd29: s = {"union"};
      6'd30: s = {"unsigned"};
      6'd31: s = {"void"};
      6'd32: s = {"volatile"};
      6'd33: s = {"while"};
      6'd34: s = {"_Alignas"};
      6'd35: s = {"_Alignof"};
      6'd36: s = {"_Atomic"};
      6'd37: s = {"_Bool"};
      6'd38: s = {"_Complex"};
      6'd39: s = {"_Generic"};
      6'd40: s = {"_Imaginary"};
      6'd41: s = {"_Noreturn"};
      6'd42: s = {"_Static", "_assert"};
      6'd43: s = {"_Thread", "_local"};
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] kw_len(input logic [5:0] k);
    kw_str_t     s;
    logic [3:0]  n;
    s = kw_str(k);
    n = '0;
    for (int i = 0; i < KwLen; i++) begin
      if (s[i*8 +: 8] != 8'd0) n = n + 4'd1;
    end
    return n;
  endfunction

  // Character at index idx (0 = first) of keyword k; 0 past the end.
  function automatic logic [7:0] kw_char(input logic [5:0] k, input logic [3:0] idx);
    kw_str_t    s;
    logic [3:0] n;
    logic [7:0] c;
    s = kw_str(k);
    n = kw_len(k);
    c = 8'd0;
    if (idx < n) c = s[(n - idx - 4'd1)*8 +: 8];
    return c;
  endfunction

  function automatic logic [5:0] sym_code(input logic [7:0] c);
    logic [5:0] v;
    case (c)
      "~": v = 6'd0;   "!": v = 6'd1;   "%": v = 6'd2;   "^": v = 6'd3;
      "&": v = 6'd4;   "*": v = 6'd5;   "(": v = 6'd6;   ")": v = 6'd7;
      "-": v = 6'd8;   "+": v = 6'd9;   "=": v = 6'd10;  ":": v = 6'd11;
      "<": v = 6'd12;  ">": v = 6'd13;  ",": v = 6'd14;  ".": v = 6'd15;
      "[": v = 6'd16;  "]": v = 6'd17;  "{": v = 6'd18;  "}": v = 6'd19;
      "|": v = 6'd20;  ";": v = 6'd21;  "/": v = 6'd22;  8'h5c: v = 6'd23;
      default: v = 6'd63;
    endcase
    return v;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  endfunction
  function automatic logic is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic is_oct(input logic [7:0] c);
    return c >= "0" && c <= "7";
  endfunction
  function automatic logic is_let(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

endpackage

### hw/rtl/c_source_lexer_top.sv
// ----------------------------------------------------------------------------
// c_source_lexer_top: a request in the input register passes through the combinational core into the result buffer.
// Throughput: one character per cycle, set by the input register and two-entry result buffer, unless the output stalls.
// A two-token step holds input while its second result drains.
// Reset: asynchronous, active low; clears mode, counters and pending results.
// ----------------------------------------------------------------------------
module c_source_lexer_top #(
  parameter int unsigned POS_BITS = csl_pkg::PosBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        final_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  token_type_o,
  output logic [15:0] start_pos_o,
  output logic [15:0] token_len_o,
  output logic [15:0] line_no_o,
  output logic [15:0] index_on_line_o,
  output logic        lex_error_o,
  output logic        end_of_run_o
);
  import csl_pkg::*;

  logic       v_q, room, go;
  logic [7:0] ch_q;
  logic       fin_q;
  step_t      st;

  assign go = v_q && room;
  assign in_stall_o = v_q && !room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else if (!in_stall_o) v_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      ch_q <= ch_i; fin_q <= final_char_i;
    end
  end

  csl_core #(.PosBits(POS_BITS)) u_core (
    .clk_i, .rst_ni, .go_i(go), .ch_i(ch_q), .fin_i(fin_q), .step_o(st)
  );

  csl_out u_out (
    .clk_i, .rst_ni, .go_i(go), .step_i(st), .room_o(room),
    .valid_o(out_valid_o), .stall_i(out_stall_i), .token_type_o, .start_pos_o,
    .token_len_o, .line_no_o, .index_on_line_o, .lex_error_o, .end_of_run_o
  );
endmodule

### hw/rtl/csl_core.sv
// ----------------------------------------------------------------------------
// csl_core
// Lexer state and single-pass classification of one registered character.
// ----------------------------------------------------------------------------
module csl_core #(
  parameter int unsigned PosBits = csl_pkg::PosBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  logic [7:0]       ch_i,
  input  logic             fin_i,
  output csl_pkg::step_t   step_o
);
  import csl_pkg::*;

  localparam logic [PosBits-1:0] PosMax = '1;

  mode_e                mode_q, mode_d;
  logic [PosBits-1:0]   pos_q, pos_d, start_q, start_d;
  logic [NumKw-1:0]     mask_q, mask_d;
  logic [7:0]           flags_q, flags_d;
  logic [15:0]          recent_q, recent_d;
  logic                 esc_q, esc_d, err_q, err_d;

  logic [PosBits-1:0]   npos;
  logic [5:0]           sym;
  logic                 is_sym, handled;
  step_t                st;

  // Number helpers operate on the flags/recent values given.
  function automatic logic [23:0] num_absorb(input logic [7:0] f, input logic [15:0] r,
                                             input logic [7:0] c);
    logic [3:0] n;
    logic [7:0] g;
    n = f[7:4];
    g = f;
    if (n >= 4'd2 && !is_oct(r[15:8])) g[3] = 1'b1;
    if (c == ".") g[0] = 1'b1;
    if (n == 4'd1 && (c == "x" || c == "X") && f[1]) g[2] = 1'b1;
    if (n < 4'd15) n = n + 4'd1;
    g[7:4] = n;
    return {g, r[7:0], c};
  endfunction

  function automatic logic num_valid(input logic [7:0] f, input logic [15:0] r);
    logic [3:0] n;
    logic [7:0] l, p;
    logic [1:0] sfx;
    logic       v;
    n = f[7:4]; l = r[7:0]; p = r[15:8];
    sfx = 2'd0;
    v = 1'b1;
    if (n >= 4'd3 && ((p == "l" && l == "l") || (p == "L" && l == "L"))) sfx = 2'd2;
    else if (l == "u" || l == "U" || l == "l" || l == "L") sfx = 2'd1;
    if (f[0] || !f[1]) v = 1'b1;
    else if (f[2] && n >= 4'd3) v = 1'b1;
    else if (f[3]) v = 1'b0;
    else if (n >= 4'd2 && sfx < 2'd2 && !is_oct(p)) v = 1'b0;
    else if (sfx == 2'd0 && !is_oct(l)) v = 1'b0;
    return v;
  endfunction

  function automatic logic [NumKw-1:0] kw_absorb(input logic [NumKw-1:0] m,
                                                 input logic [3:0] idx,
                                                 input logic [7:0] c);
    logic [NumKw-1:0] o;
    o = m;
    for (int k = 0; k < NumKw; k++) begin
      if (idx >= 4'd15 || kw_char(6'(k), idx) != c) o[k] = 1'b0;
    end
    return o;
  endfunction

  function automatic logic [6:0] kw_type(input logic [NumKw-1:0] m, input logic [3:0] n);
    logic [6:0] t;
    t = TypeIdent;
    for (int k = NumKw - 1; k >= 0; k--) begin
      if (m[k] && kw_len(6'(k)) == n) t = TypeKw0 + 7'(k);
    end
    return t;
  endfunction

  function automatic result_t mk(input logic [6:0] t, input logic [PosBits-1:0] s,
                                 input logic [PosBits-1:0] e);
    result_t r;
    logic [PosBits-1:0] d;
    d = e - s;
    r.tok_type = t;
    r.start = 16'(s);
    r.len = 16'(d);
    r.err = 1'b0;
    return r;
  endfunction

  localparam result_t ErrRes = '{tok_type: '0, start: '0, len: '0, err: 1'b1};

  task automatic push(inout step_t s, input result_t r);
    if (s.cnt == 2'd0) s.r0 = r;
    else s.r1 = r;
    s.cnt = s.cnt + 2'd1;
  endtask

  always_comb begin
    logic [23:0] na;
    mode_d = mode_q; pos_d = pos_q; start_d = start_q; mask_d = mask_q;
    flags_d = flags_q; recent_d = recent_q; esc_d = esc_q; err_d = err_q;
    st = '0;
    handled = 1'b0;
    na = '0;
    npos = (pos_q < PosMax) ? pos_q + 1'b1 : pos_q;
    sym = sym_code(ch_i);
    is_sym = sym != 6'd63;
    if (go_i && !err_q) begin
      unique case (mode_q)
        ModeNum: begin
          if (is_ws(ch_i) || (ch_i != "." && is_sym)) begin
            if (num_valid(flags_q, recent_q)) begin
              push(st, mk(TypeNumber, start_q, pos_q));
              mode_d = ModeIdle;
            end else begin
              push(st, ErrRes); err_d = 1'b1; mode_d = ModeIdle;
            end
          end else begin
            handled = 1'b1;
            na = num_absorb(flags_q, recent_q, ch_i);
            flags_d = na[23:16]; recent_d = na[15:0];
            if (fin_i) begin
              mode_d = ModeIdle;
              if (num_valid(na[23:16], na[15:0])) push(st, mk(TypeNumber, start_q, npos));
              else begin push(st, ErrRes); err_d = 1'b1; end
            end
          end
        end
        ModeWord: begin
          if (is_let(ch_i) || is_dig(ch_i) || ch_i == "_") begin
            handled = 1'b1;
            mask_d = kw_absorb(mask_q, flags_q[7:4], ch_i);
            flags_d[7:4] = (flags_q[7:4] < 4'd15) ? flags_q[7:4] + 4'd1 : flags_q[7:4];
            if (fin_i) begin
              push(st, mk(kw_type(mask_d, flags_d[7:4]), start_q, npos));
              mode_d = ModeIdle;
            end
          end else begin
            push(st, mk(kw_type(mask_q, flags_q[7:4]), start_q, pos_q));
            mode_d = ModeIdle;
          end
        end
        ModeStr: begin
          handled = 1'b1;
          if (ch_i == 8'h0a) begin
            push(st, ErrRes); err_d = 1'b1; mode_d = ModeIdle;
          end else if (ch_i == 8'h22 && !esc_q) begin
            push(st, mk(TypeString, start_q, npos)); mode_d = ModeIdle;
          end else if (fin_i) begin
            push(st, ErrRes); err_d = 1'b1; mode_d = ModeIdle;
          end else begin
            esc_d = (ch_i == 8'h5c) && !esc_q;
          end
        end
        default: ;
      endcase
      if (!handled && !err_d) begin
        if (is_ws(ch_i)) begin
          st.nl = (ch_i == 8'h0a);
        end else if (is_sym) begin
          push(st, mk(7'(sym), pos_q, pos_q + 1'b1));
          st.r0.len = (st.cnt == 2'd1) ? 16'd1 : st.r0.len;
          st.r1.len = 16'd1;
        end else if (ch_i == 8'h22) begin
          mode_d = ModeStr; start_d = pos_q; flags_d = '0; recent_d = '0;
          esc_d = 1'b0; mask_d = '1;
          if (fin_i) begin push(st, ErrRes); err_d = 1'b1; mode_d = ModeIdle; end
        end else if (is_dig(ch_i)) begin
          start_d = pos_q; esc_d = 1'b0; mask_d = '1;
          na = num_absorb({6'd0, ch_i == "0", 1'b0}, 16'd0, ch_i);
          flags_d = na[23:16]; recent_d = na[15:0]; mode_d = ModeNum;
          if (fin_i) begin
            mode_d = ModeIdle;
            if (num_valid(na[23:16], na[15:0])) push(st, mk(TypeNumber, pos_q, npos));
            else begin push(st, ErrRes); err_d = 1'b1; end
          end
        end else if (is_let(ch_i) || ch_i == "_") begin
          start_d = pos_q; esc_d = 1'b0; recent_d = '0;
          mask_d = kw_absorb('1, 4'd0, ch_i);
          flags_d = 8'h10; mode_d = ModeWord;
          if (fin_i) begin
            push(st, mk(kw_type(mask_d, 4'd1), pos_q, npos)); mode_d = ModeIdle;
          end
        end else begin
          push(st, ErrRes); err_d = 1'b1; mode_d = ModeIdle;
        end
      end
      pos_d = npos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle; pos_q <= '0; start_q <= '0; mask_q <= '1;
      flags_q <= '0; recent_q <= '0; esc_q <= 1'b0; err_q <= 1'b0;
    end else begin
      mode_q <= mode_d; pos_q <= pos_d; start_q <= start_d; mask_q <= mask_d;
      flags_q <= flags_d; recent_q <= recent_d; esc_q <= esc_d; err_q <= err_d;
    end
  end

  assign step_o = st;
endmodule

### hw/rtl/csl_out.sv
// ----------------------------------------------------------------------------
// csl_out
// Line counters and two-entry result buffer with serialized output.
// ----------------------------------------------------------------------------
module csl_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  csl_pkg::step_t    step_i,
  output logic              room_o,
  output logic              valid_o,
  input  logic              stall_i,
  output logic [6:0]        token_type_o,
  output logic [15:0]       start_pos_o,
  output logic [15:0]       token_len_o,
  output logic [15:0]       line_no_o,
  output logic [15:0]       index_on_line_o,
  output logic              lex_error_o,
  output logic              end_of_run_o
);
  import csl_pkg::*;

  typedef struct packed {
    result_t     r;
    logic [15:0] line;
    logic [15:0] idx;
    logic        last;
  } ent_t;

  logic [15:0] line_q, line_d, lt_q, lt_d;
  ent_t        buf_q [2];
  logic [1:0]  cnt_q;
  logic        rd_q;
  ent_t        e0, e1;
  logic        pop;

  always_comb begin
    line_d = line_q; lt_d = lt_q;
    e0 = '0; e1 = '0;
    e0.r = step_i.r0; e1.r = step_i.r1;
    e0.line = line_q; e1.line = line_q;
    e0.idx = lt_q;
    if (!step_i.r0.err && step_i.cnt != 2'd0 && lt_d != 16'hffff) lt_d = lt_d + 16'd1;
    e1.idx = lt_d;
    if (!step_i.r1.err && step_i.cnt == 2'd2 && lt_d != 16'hffff) lt_d = lt_d + 16'd1;
    if (step_i.r0.err) e0.r = '{tok_type: '0, start: '0, len: '0, err: 1'b1};
    if (step_i.r0.err) e0.line = '0;
    if (step_i.r0.err) e0.idx = '0;
    if (step_i.r1.err) begin e1.line = '0; e1.idx = '0; end
    e0.last = step_i.cnt == 2'd1;
    e1.last = 1'b1;
    if (go_i && step_i.nl) begin
      if (line_q != 16'hffff) line_d = line_q + 16'd1;
      lt_d = '0;
    end
  end

  assign pop = valid_o && !stall_i;
  assign room_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop) || (cnt_q == 2'd2 && pop && rd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0; lt_q <= '0; cnt_q <= '0; rd_q <= 1'b0;
    end else begin
      line_q <= line_d; lt_q <= lt_d;
      if (go_i && step_i.cnt != 2'd0) begin
        buf_q[0] <= e0; buf_q[1] <= e1; cnt_q <= step_i.cnt; rd_q <= 1'b0;
      end else if (pop) begin
        if (cnt_q == 2'd2 && !rd_q) rd_q <= 1'b1;
        else begin cnt_q <= '0; rd_q <= 1'b0; end
      end
    end
  end

  ent_t cur;
  assign cur = rd_q ? buf_q[1] : buf_q[0];
  assign valid_o         = cnt_q != 2'd0;
  assign token_type_o    = cur.r.tok_type;
  assign start_pos_o     = cur.r.start;
  assign token_len_o     = cur.r.len;
  assign line_no_o       = cur.line;
  assign index_on_line_o = cur.idx;
  assign lex_error_o     = cur.r.err;
  assign end_of_run_o    = cur.last;
endmodule

### hw/rtl/csl_checker.sv
// ----------------------------------------------------------------------------
// csl_checker
// Port-level checks on the lexer's result stream.
// ----------------------------------------------------------------------------
`include "c_source_lexer_top_assert.svh"
module csl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [6:0]  token_type_o,
  input logic [15:0] token_len_o,
  input logic        lex_error_o,
  input logic        end_of_run_o
);
  `CSL_ASSERT_IMP(a_err_zero, clk_i, rst_ni, out_valid_o && lex_error_o,
    token_type_o == 7'd0 && token_len_o == 16'd0 && end_of_run_o)
  `CSL_ASSERT_IMP(a_type_rng, clk_i, rst_ni, out_valid_o, token_type_o <= 7'd70)
  `CSL_ASSERT_IMP(a_sym_len, clk_i, rst_ni, out_valid_o && !lex_error_o && token_type_o < 7'd24,
    token_len_o == 16'd1)
  `CSL_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(token_type_o))
endmodule

bind c_source_lexer_top csl_checker u_chk (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .token_type_o, .token_len_o,
  .lex_error_o, .end_of_run_o
);

### test/c_source_lexer_top_tb.sv
// ----------------------------------------------------------------------------
// C source lexer testbench
// Streams C-like text into the lexer one character per request and checks
// every token against a behavioral lexer kept in a scoreboard, with random
// idling on both channels and one sticky error at the end of the text.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

typedef struct {
  logic [6:0]  kind;
  logic [15:0] start;
  logic [15:0] len;
  logic [15:0] line;
  logic [15:0] index;
  logic        err;
  logic        eor;
} token_t;

class lexer_scoreboard;
  token_t          exp_q[$];
  int              errors;
  int              tokens_seen;
  int              error_results;
  string           kwtab[44];
  string           symtab;
  csl_pkg::mode_e  mode;
  logic [15:0]     pos, tstart, line_cnt, line_tok;
  logic [7:0]      nflags;
  logic [15:0]     recent;
  logic            esc, err_seen;
  string           wtext;

  function new();
    kwtab = '{"auto", "break", "case", "char", "const", "continue", "default", "do",
              "double", "else", "enum", "extern", "float", "for", "goto", "if",
              "inline", "int", "long", "register", "restrict", "return", "short",
              "signed", "sizeof", "static", "struct", "switch", "typedef", "union",
              "unsigned", "void", "volatile", "while", "_Alignas", "_Alignof",
              "_Atomic", "_Bool", "_Complex", "_Generic", "_Imaginary", "_Noreturn",
              "_Static", "_Thread"};
    kwtab[42] = {kwtab[42], "_assert"};
    kwtab[43] = {kwtab[43], "_local"};
    symtab = "~!%^&*()-+=:<>,.[]{}|;/\\";
    mode = csl_pkg::ModeIdle;
    pos = '0; tstart = '0; line_cnt = '0; line_tok = '0;
    nflags = '0; recent = '0; esc = 0; err_seen = 0; wtext = "";
    errors = 0; tokens_seen = 0; error_results = 0;
  endfunction

  function bit ws(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  endfunction
  function bit dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function bit oct(logic [7:0] c);
    return c >= "0" && c <= "7";
  endfunction
  function bit letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function int sym(logic [7:0] c);
    for (int i = 0; i < 24; i++) if (symtab[i] == c) return i;
    return -1;
  endfunction

  function logic [15:0] next_pos();
    return (pos == 16'hffff) ? pos : pos + 16'd1;
  endfunction

  function void push_tok(logic [6:0] kind, logic [15:0] start, logic [15:0] len);
    token_t t;
    t.kind = kind; t.start = start; t.len = len;
    t.line = line_cnt; t.index = line_tok; t.err = 0; t.eor = 0;
    exp_q.push_back(t);
    if (line_tok != 16'hffff) line_tok++;
  endfunction

  function void push_err();
    token_t t;
    t.kind = '0; t.start = '0; t.len = '0; t.line = '0; t.index = '0;
    t.err = 1; t.eor = 0;
    exp_q.push_back(t);
    err_seen = 1;
    mode = csl_pkg::ModeIdle;
  endfunction

  function void bump();
    if (nflags[7:4] != 4'd15) nflags[7:4] = nflags[7:4] + 4'd1;
  endfunction

  function void num_absorb(logic [7:0] c);
    int n;
    n = nflags[7:4];
    if (n >= 2 && !oct(recent[15:8])) nflags[3] = 1;
    if (c == ".") nflags[0] = 1;
    if (n == 1 && (c == "x" || c == "X") && nflags[1]) nflags[2] = 1;
    recent = {recent[7:0], c};
    bump();
  endfunction

  function bit num_ok();
    int n, sfx;
    logic [7:0] last, prev;
    n = nflags[7:4];
    last = recent[7:0];
    prev = recent[15:8];
    sfx = 0;
    if (nflags[0] || !nflags[1]) return 1;
    if (nflags[2] && n >= 3) return 1;
    if (n >= 3 && ((prev == "l" && last == "l") || (prev == "L" && last == "L"))) sfx = 2;
    else if (last == "u" || last == "U" || last == "l" || last == "L") sfx = 1;
    if (nflags[3]) return 0;
    if (n >= 2 && sfx < 2 && !oct(prev)) return 0;
    if (sfx == 0 && !oct(last)) return 0;
    return 1;
  endfunction

  function void word_absorb(logic [7:0] c);
    string s;
    s = " ";
    s[0] = c;
    if (wtext.len() < 15) wtext = {wtext, s};
    bump();
  endfunction

  function logic [6:0] word_kind();
    if (nflags[7:4] < 4'd15)
      for (int k = 0; k < 44; k++) if (kwtab[k] == wtext) return csl_pkg::TypeKw0 + k;
    return csl_pkg::TypeIdent;
  endfunction

  function void finish_num(logic [15:0] stop);
    if (num_ok()) push_tok(csl_pkg::TypeNumber, tstart, stop - tstart);
    else push_err();
    if (!err_seen) mode = csl_pkg::ModeIdle;
  endfunction

  function void finish_word(logic [15:0] stop);
    push_tok(word_kind(), tstart, stop - tstart);
    mode = csl_pkg::ModeIdle;
  endfunction

  function void open_token(csl_pkg::mode_e m);
    mode = m; tstart = pos; nflags = '0; recent = '0; esc = 0; wtext = "";
  endfunction

  function void note_char(logic [7:0] c, logic fin);
    int  n0, s;
    bit  handled;
    if (err_seen) return;
    n0 = exp_q.size();
    handled = 0;
    case (mode)
      csl_pkg::ModeNum: begin
        if (ws(c) || (c != "." && sym(c) >= 0)) finish_num(pos);
        else begin
          num_absorb(c);
          if (fin) finish_num(next_pos());
          handled = 1;
        end
      end
      csl_pkg::ModeWord: begin
        if (letter(c) || dig(c) || c == "_") begin
          word_absorb(c);
          if (fin) finish_word(next_pos());
          handled = 1;
        end else finish_word(pos);
      end
      csl_pkg::ModeStr: begin
        handled = 1;
        if (c == 8'h0a) push_err();
        else if (c == "\"" && !esc) begin
          push_tok(csl_pkg::TypeString, tstart, next_pos() - tstart);
          mode = csl_pkg::ModeIdle;
        end else if (fin) push_err();
        else esc = (c == "\\" && !esc);
      end
      default: ;
    endcase
    if (!handled && !err_seen) begin
      s = sym(c);
      if (c == 8'h0a) begin
        if (line_cnt != 16'hffff) line_cnt++;
        line_tok = '0;
      end else if (ws(c)) begin
      end else if (s >= 0) push_tok(s, pos, 16'd1);
      else if (c == "\"") begin
        open_token(csl_pkg::ModeStr);
        if (fin) push_err();
      end else if (dig(c)) begin
        open_token(csl_pkg::ModeNum);
        if (c == "0") nflags[1] = 1;
        num_absorb(c);
        if (fin) finish_num(next_pos());
      end else if (letter(c) || c == "_") begin
        open_token(csl_pkg::ModeWord);
        word_absorb(c);
        if (fin) finish_word(next_pos());
      end else push_err();
    end
    pos = next_pos();
    if (exp_q.size() > n0) exp_q[exp_q.size()-1].eor = 1;
  endfunction

  function void cmp(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
      errors++;
    end
  endfunction

  function void check(token_t got);
    token_t e;
    if (exp_q.size() == 0) begin
      $display("%0t unexpected token: expected none actual type %0d", $time, got.kind);
      errors++;
      return;
    end
    e = exp_q.pop_front();
    tokens_seen++;
    if (e.err) error_results++;
    cmp("token_type", e.kind, got.kind);
    cmp("start_pos", e.start, got.start);
    cmp("token_len", e.len, got.len);
    cmp("line_no", e.line, got.line);
    cmp("index_on_line", e.index, got.index);
    cmp("lex_error", e.err, got.err);
    cmp("end_of_run", e.eor, got.eor);
  endfunction
endclass

module c_source_lexer_top_tb;
  typedef struct {
    logic [7:0] ch;
    logic       fin;
  } req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  ch = 8'd0;
  logic        fin = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  tok_kind;
  logic [15:0] start_pos, token_len, line_no, index_on_line;
  logic        lex_error, end_of_run;

  lexer_scoreboard sb = new();
  req_t            stim_q[$];
  int              sent = 0;
  int              n_req;
  int              pause_at;
  int              gap = 0, sgap = 0, hold_cnt = 0;
  bit              pause_done = 0, hold_done = 0;

  c_source_lexer_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .ch_i(ch), .final_char_i(fin),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .token_type_o(tok_kind), .start_pos_o(start_pos), .token_len_o(token_len),
    .line_no_o(line_no), .index_on_line_o(index_on_line),
    .lex_error_o(lex_error), .end_of_run_o(end_of_run)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic add_text(string s, bit fin_last);
    req_t r;
    for (int i = 0; i < s.len(); i++) begin
      r.ch = s[i];
      r.fin = fin_last && (i == s.len() - 1);
      stim_q.push_back(r);
    end
  endtask

  function automatic string one_char(logic [7:0] c);
    string s;
    s = " ";
    s[0] = c;
    return s;
  endfunction

  function automatic string pick(string set);
    return one_char(set[$urandom_range(0, set.len() - 1)]);
  endfunction

  task automatic add_token();
    string s, wchars, seps;
    int    n;
    wchars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    seps = "  \t\r\n;,)(+-*";
    s = "";
    case ($urandom_range(0, 9))
      0, 1: s = pick(sb.symtab);
      2: s = sb.kwtab[$urandom_range(0, 43)];
      3: begin
        s = pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_");
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 20) : $urandom_range(0, 6);
        repeat (n) s = {s, pick(wchars)};
      end
      4: begin
        case ($urandom_range(0, 3))
          0: begin
            s = pick("123456789");
            repeat ($urandom_range(0, 4)) s = {s, pick("0123456789")};
            if ($urandom_range(0, 2) == 0) s = {s, pick("uUlL")};
          end
          1: begin
            s = {"0", pick("xX")};
            repeat ($urandom_range(1, 4)) s = {s, pick("0123456789abcdefABCDEF")};
          end
          2: begin
            s = "0";
            repeat ($urandom_range(0, 3)) s = {s, pick("01234567")};
            case ($urandom_range(0, 3))
              0: s = {s, pick("uUlL")};
              1: s = {s, ($urandom_range(0, 1) ? "ll" : "LL")};
              default: ;
            endcase
          end
          default: begin
            s = {pick("0123456789"), "."};
            repeat ($urandom_range(0, 3)) s = {s, pick("0123456789")};
          end
        endcase
      end
      5, 6: begin
        s = "\"";
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 4) == 0)
            s = {s, "\\", one_char($urandom_range(8'h20, 8'h7e))};
          else begin
            n = $urandom_range(8'h20, 8'h7e);
            if (n == 8'h22 || n == 8'h5c) n = "a";
            s = {s, one_char(n)};
          end
        end
        s = {s, "\""};
      end
      default: s = pick(" \t\r\n");
    endcase
    add_text(s, $urandom_range(0, 9) == 0);
    add_text(pick(seps), $urandom_range(0, 15) == 0);
  endtask

  initial begin
    req_t r;
    add_text("int\"a\\\"b\"0x1F 017L 0.5~\\\n_Z9+", 1);
    while (stim_q.size() < 1400) add_token();
    add_text("abc", 0);
    r.ch = 8'hff; r.fin = 0;
    stim_q.push_back(r);
    repeat (15) begin
      r.ch = $urandom_range(0, 255);
      r.fin = $urandom_range(0, 1);
      stim_q.push_back(r);
    end
    n_req = stim_q.size();
    pause_at = n_req / 2;
  end

  always @(posedge clk_i) begin : drive_proc
    bit acc;
    acc = in_valid && !in_stall;
    if (acc) begin
      sb.note_char(ch, fin);
      sent++;
    end
    if (rst_ni && (!in_valid || acc)) begin
      if (gap > 0) begin
        gap--;
        in_valid <= 1'b0;
      end else if (sent == pause_at && !pause_done) begin
        if (sb.exp_q.size() == 0) pause_done = 1;
        in_valid <= 1'b0;
      end else if (sent < n_req) begin
        if (sent < n_req - 200 && $urandom_range(0, 5) == 0) begin
          gap = $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          ch <= stim_q[sent].ch;
          fin <= stim_q[sent].fin;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : recv_proc
    token_t got;
    if (out_valid && !out_stall) begin
      got.kind = tok_kind; got.start = start_pos; got.len = token_len;
      got.line = line_no; got.index = index_on_line;
      got.err = lex_error; got.eor = end_of_run;
      sb.check(got);
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (!hold_done && sent >= 300) begin
      hold_done = 1;
      hold_cnt = 80;
      out_stall <= 1'b1;
    end else if (sgap > 0) begin
      sgap--;
      out_stall <= 1'b1;
    end else if (sent < n_req - 200 && $urandom_range(0, 5) == 0) begin
      sgap = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (sent < n_req) @(posedge clk_i);
    while (sb.exp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Run covered %0d characters and %0d tokens, %0d of them error results.",
             sent, sb.tokens_seen, sb.error_results);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Timeout with %0d requests sent", sent);
    $display("DONE: errors detected");
    $finish;
  end
endmodule

### c_source_lexer_top.f
+incdir+hw/rtl
hw/rtl/csl_pkg.sv
hw/rtl/csl_core.sv
hw/rtl/csl_out.sv
hw/rtl/c_source_lexer_top.sv
hw/rtl/csl_checker.sv
test/c_source_lexer_top_tb.sv
